FILE: design/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes of the periodic timer table: item kinds, result
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int RESULT_LIMIT   = 64;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_PAUSE  = 3'd2;
  localparam logic [2:0] KIND_RESUME = 3'd3;
  localparam logic [2:0] KIND_DELETE = 3'd4;

  localparam logic [2:0] STAT_FIRED     = 3'd0;
  localparam logic [2:0] STAT_ADDED     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_DONE      = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [2:0] STAT_BAD_INTVL = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;        // run an add or control word this cycle
    logic tick_start;  // advance time, clear the scan
    logic issue;       // read the slot at the scan pointer
    logic flush;       // emit the held fire word as final
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;       // no slot ever claimed
    logic last_issue;  // scan pointer sits on the last claimed slot
  } sts_t;

endpackage : ptt_pkg
`default_nettype wire

FILE: design/periodic_task_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Table of append-only periodic timers with a seconds counter.
// ----------------------------------------------------------------------------
// Words are accepted when start is high and busy is low. Add, pause, resume
// and delete words each give a single result word on the out_ ports,
// marked by out_valid, in the cycle after acceptance, and busy stays low
// so the next word may follow at once. A tick word scans the claimed
// slots, reading one slot per cycle from the period and last-fire RAMs,
// then drains the RAM read latency and emits the final fire word. Fire
// words come out at most one per cycle with out_last set on the final one;
// a tick with nothing due gives no word. out_valid lasts exactly one cycle
// and cannot be held off, so every word must be captured when it appears.
// No memory clearing pass follows reset.
// ----------------------------------------------------------------------------
module periodic_task_timer_table #(
  parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [30:0] in_interval_seconds,
  input  wire logic [6:0]  in_target_id,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [6:0]       out_task_number,
  output logic             out_last
);

  ptt_pkg::cmd_t cmd;
  ptt_pkg::sts_t sts;

  ptt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  ptt_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_kind             (in_kind),
    .in_interval_seconds (in_interval_seconds),
    .in_target_id        (in_target_id),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_task_number     (out_task_number),
    .out_last            (out_last)
  );

endmodule : periodic_task_timer_table
`default_nettype wire

FILE: design/ptt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : ptt_ram
`default_nettype wire

FILE: design/ptt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ctrl
// Controller of the timer table: accepts words, sequences the tick scan.
// ----------------------------------------------------------------------------
module ptt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [2:0]    in_kind,
  input  wire ptt_pkg::sts_t sts,
  output logic               busy,
  output ptt_pkg::cmd_t      cmd
);

  ptt_pkg::state_t state_r;
  ptt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ptt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_kind == ptt_pkg::KIND_TICK) begin
            cmd.tick_start = 1'b1;
            if (!sts.empty) begin
              state_nxt = ptt_pkg::ST_SCAN;
            end
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      ptt_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = ptt_pkg::ST_DRAIN;
        end
      end
      // last slot is evaluated here
      ptt_pkg::ST_DRAIN: begin
        state_nxt = ptt_pkg::ST_FLUSH;
      end
      ptt_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ptt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ptt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule : ptt_ctrl
`default_nettype wire

FILE: design/ptt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_dp
// Datapath of the timer table: time counter, slot flags, period and
// last-fire RAMs, scan pointer, fire evaluation and the result register.
// ----------------------------------------------------------------------------
module ptt_dp #(
  parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ptt_pkg::cmd_t cmd,
  input  wire logic [2:0]    in_kind,
  input  wire logic [30:0]   in_interval_seconds,
  input  wire logic [6:0]    in_target_id,
  output ptt_pkg::sts_t      sts,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [6:0]         out_task_number,
  output logic               out_last
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam int CW = (UW > 7) ? UW : 7;
  localparam int IW = (AW + 1 > 7) ? AW + 1 : 7;

  logic [31:0]   seconds_r,   seconds_nxt;
  logic [UW-1:0] used_r,      used_nxt;
  logic          active_r [SLOT_COUNT];
  logic          active_nxt [SLOT_COUNT];
  logic          paused_r [SLOT_COUNT];
  logic          paused_nxt [SLOT_COUNT];
  logic [AW-1:0] idx_r,       idx_nxt;
  logic          rd_vld_r,    rd_vld_nxt;
  logic [AW-1:0] eval_idx_r,  eval_idx_nxt;
  logic [6:0]    fire_cnt_r,  fire_cnt_nxt;
  logic          pend_vld_r,  pend_vld_nxt;
  logic [6:0]    pend_id_r,   pend_id_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [6:0]    out_task_r,  out_task_nxt;
  logic          out_last_r,  out_last_nxt;

  logic [30:0]   per_rd;
  logic [31:0]   lf_rd;
  logic          per_we;
  logic          lf_we;
  logic [AW-1:0] lf_waddr;
  logic [AW-1:0] add_addr;

  logic [CW-1:0] tgt_ext;
  logic [CW-1:0] tgt_m1;
  logic [AW-1:0] tgt_idx;
  logic          tgt_ok;
  logic [AW-1:0] flag_idx;
  logic          act_f;
  logic          pau_f;
  logic [IW-1:0] eval_id_ext;
  logic [IW-1:0] add_id_ext;
  logic [31:0]   elapsed;
  logic          fire;
  logic          add_room;

  // -------------------- slot RAMs --------------------
  ptt_ram #(.WIDTH(31), .DEPTH(SLOT_COUNT)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (add_addr),
    .wdata (in_interval_seconds),
    .re    (cmd.issue),
    .raddr (idx_r),
    .rdata (per_rd)
  );

  ptt_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_lf_ram (
    .clk   (clk),
    .we    (lf_we),
    .waddr (lf_waddr),
    .wdata (seconds_r),
    .re    (cmd.issue),
    .raddr (idx_r),
    .rdata (lf_rd)
  );

  // -------------------- decode --------------------
  assign add_addr    = used_r[AW-1:0];
  assign add_room    = CW'(used_r) < CW'(SLOT_COUNT);
  assign tgt_ext     = CW'(in_target_id);
  assign tgt_m1      = tgt_ext - CW'(1);
  assign tgt_idx     = tgt_m1[AW-1:0];
  assign tgt_ok      = (tgt_ext != '0) && (tgt_ext <= CW'(used_r)) &&
                       (tgt_ext <= CW'(SLOT_COUNT));
  assign flag_idx    = rd_vld_r ? eval_idx_r : tgt_idx;
  assign act_f       = active_r[flag_idx];
  assign pau_f       = paused_r[flag_idx];
  assign eval_id_ext = IW'(eval_idx_r) + IW'(1);
  assign add_id_ext  = IW'(used_r) + IW'(1);

  // elapsed time wraps modulo 2^32
  assign elapsed = seconds_r - lf_rd;
  assign fire    = rd_vld_r && act_f && !pau_f && (elapsed >= {1'b0, per_rd}) &&
                   (fire_cnt_r < 7'(ptt_pkg::RESULT_LIMIT));

  assign sts.empty      = (used_r == '0);
  assign sts.last_issue = (UW'(idx_r) == used_r - UW'(1));

  always_comb begin
    seconds_nxt    = seconds_r;
    used_nxt       = used_r;
    active_nxt     = active_r;
    paused_nxt     = paused_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = cmd.issue;
    eval_idx_nxt   = idx_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_vld_nxt   = pend_vld_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_last_nxt   = out_last_r;
    per_we         = 1'b0;
    lf_we          = 1'b0;
    lf_waddr       = add_addr;

    if (cmd.tick_start) begin
      seconds_nxt  = seconds_r + 32'd1;
      idx_nxt      = '0;
      fire_cnt_nxt = '0;
      pend_vld_nxt = 1'b0;
    end

    if (cmd.issue) begin
      idx_nxt = idx_r + AW'(1);
    end

    // hold each fire until the next one shows it is not the final word
    if (fire) begin
      lf_we        = 1'b1;
      lf_waddr     = eval_idx_r;
      fire_cnt_nxt = fire_cnt_r + 7'd1;
      pend_vld_nxt = 1'b1;
      pend_id_nxt  = eval_id_ext[6:0];
      if (pend_vld_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ptt_pkg::STAT_FIRED;
        out_task_nxt   = pend_id_r;
        out_last_nxt   = 1'b0;
      end
    end

    if (cmd.flush) begin
      pend_vld_nxt = 1'b0;
      if (pend_vld_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ptt_pkg::STAT_FIRED;
        out_task_nxt   = pend_id_r;
        out_last_nxt   = 1'b1;
      end
    end

    if (cmd.exec) begin
      out_last_nxt = 1'b1;
      out_task_nxt = '0;
      if (in_kind == ptt_pkg::KIND_ADD) begin
        out_valid_nxt = 1'b1;
        if (in_interval_seconds == '0) begin
          out_status_nxt = ptt_pkg::STAT_BAD_INTVL;
        end else if (!add_room) begin
          out_status_nxt = ptt_pkg::STAT_FULL;
        end else begin
          per_we               = 1'b1;
          lf_we                = 1'b1;
          active_nxt[add_addr] = 1'b1;
          paused_nxt[add_addr] = 1'b0;
          used_nxt             = used_r + UW'(1);
          out_status_nxt       = ptt_pkg::STAT_ADDED;
          out_task_nxt         = add_id_ext[6:0];
        end
      end else if (in_kind == ptt_pkg::KIND_PAUSE || in_kind == ptt_pkg::KIND_RESUME ||
                   in_kind == ptt_pkg::KIND_DELETE) begin
        out_valid_nxt = 1'b1;
        if (!tgt_ok || !act_f) begin
          out_status_nxt = ptt_pkg::STAT_NOT_FOUND;
        end else begin
          out_status_nxt = ptt_pkg::STAT_DONE;
          out_task_nxt   = in_target_id;
          case (in_kind)
            ptt_pkg::KIND_PAUSE:  paused_nxt[tgt_idx] = 1'b1;
            ptt_pkg::KIND_RESUME: paused_nxt[tgt_idx] = 1'b0;
            default:              active_nxt[tgt_idx] = 1'b0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r   <= '0;
      used_r      <= '0;
      active_r    <= '{default: 1'b0};
      paused_r    <= '{default: 1'b0};
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      fire_cnt_r  <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seconds_r   <= seconds_nxt;
      used_r      <= used_nxt;
      active_r    <= active_nxt;
      paused_r    <= paused_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r   <= eval_idx_nxt;
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_number = out_task_r;
  assign out_last        = out_last_r;

  // -------------------- assertions --------------------
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(used_r) <= CW'(SLOT_COUNT))
    else $error("slot count exceeds table size");

  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_start |=> seconds_r == $past(seconds_r) + 32'd1)
    else $error("time did not advance on tick");

  a_no_add_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue || rd_vld_r) |-> !per_we)
    else $error("period write during scan");

  a_final_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ptt_pkg::STAT_FIRED && out_last_r) |->
      $past(cmd.flush))
    else $error("final fire word not from flush");

  a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= 7'(ptt_pkg::RESULT_LIMIT))
    else $error("too many fires in one tick");

endmodule : ptt_dp
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the periodic timer table against a cycle-free table model.
// A directed opening covers rejected adds, not-found controls, repeated
// pause and resume, delete and unused kind codes. Random traffic then fills
// the table, runs past full and keeps ticking with short periods so that
// many slots fire per tick. Every result word is compared field by field
// with the model's queue of due reports.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS        = ptt_pkg::SLOT_COUNT_DEF;
  localparam int RANDOM_CMDS  = 385;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;

  typedef struct {
    logic [2:0]  kind;
    logic [30:0] interval;
    logic [6:0]  target;
    int unsigned gap;
  } timer_cmd_t;

  typedef struct {
    logic [2:0] status;
    logic [6:0] task_number;
    logic       last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_kind = ptt_pkg::KIND_TICK;
  logic [30:0] in_interval_seconds = '0;
  logic [6:0]  in_target_id = '0;
  wire         busy;
  wire         out_valid;
  wire  [2:0]  out_status;
  wire  [6:0]  out_task_number;
  wire         out_last;

  periodic_task_timer_table u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_interval_seconds (in_interval_seconds),
    .in_target_id        (in_target_id),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_task_number     (out_task_number),
    .out_last            (out_last)
  );

  always #2 clk = ~clk;

  // Table model state
  logic [30:0] slot_period [SLOTS];
  logic [31:0] slot_stamp  [SLOTS];
  bit          slot_paused [SLOTS];
  bit          slot_active [SLOTS];
  int unsigned slots_claimed = 0;
  logic [31:0] clock_secs = '0;

  timer_cmd_t  cmd_queue [$];
  report_t     due_reports [$];
  int unsigned total_words = 0;
  int unsigned words_taken = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  function automatic void push_report(logic [2:0] status, logic [6:0] id, logic fin);
    report_t r;
    r.status      = status;
    r.task_number = id;
    r.last        = fin;
    due_reports.push_back(r);
  endfunction

  // Advance the table by one accepted word and queue the reports it causes.
  function automatic void advance_table(logic [2:0] kind, logic [30:0] interval,
                                        logic [6:0] target);
    int fired [$];
    int idx;
    logic [31:0] elapsed;
    if (kind == ptt_pkg::KIND_TICK) begin
      clock_secs = clock_secs + 32'd1;
      for (int i = 0; i < slots_claimed; i++) begin
        elapsed = clock_secs - slot_stamp[i];
        if (slot_active[i] && !slot_paused[i] && elapsed >= {1'b0, slot_period[i]}
            && fired.size() < ptt_pkg::RESULT_LIMIT) begin
          slot_stamp[i] = clock_secs;
          fired.push_back(i + 1);
        end
      end
      foreach (fired[k])
        push_report(ptt_pkg::STAT_FIRED, 7'(fired[k]), k == fired.size() - 1);
    end else if (kind == ptt_pkg::KIND_ADD) begin
      if (interval == '0) begin
        push_report(ptt_pkg::STAT_BAD_INTVL, 7'd0, 1'b1);
      end else if (slots_claimed >= SLOTS) begin
        push_report(ptt_pkg::STAT_FULL, 7'd0, 1'b1);
      end else begin
        slot_period[slots_claimed] = interval;
        slot_stamp[slots_claimed]  = clock_secs;
        slot_paused[slots_claimed] = 1'b0;
        slot_active[slots_claimed] = 1'b1;
        slots_claimed++;
        push_report(ptt_pkg::STAT_ADDED, 7'(slots_claimed), 1'b1);
      end
    end else if (kind == ptt_pkg::KIND_PAUSE || kind == ptt_pkg::KIND_RESUME ||
                 kind == ptt_pkg::KIND_DELETE) begin
      idx = int'(target) - 1;
      if (target == '0 || target > slots_claimed || !slot_active[idx]) begin
        push_report(ptt_pkg::STAT_NOT_FOUND, 7'd0, 1'b1);
      end else begin
        if (kind == ptt_pkg::KIND_PAUSE)
          slot_paused[idx] = 1'b1;
        else if (kind == ptt_pkg::KIND_RESUME)
          slot_paused[idx] = 1'b0;
        else
          slot_active[idx] = 1'b0;
        push_report(ptt_pkg::STAT_DONE, target, 1'b1);
      end
    end
  endfunction

  // Gaps come in bursts: every third stretch of 24 words runs back to back.
  function automatic void queue_cmd(logic [2:0] kind, logic [30:0] interval,
                                    logic [6:0] target);
    timer_cmd_t c;
    c.kind     = kind;
    c.interval = interval;
    c.target   = target;
    c.gap      = ((total_words / 24) % 3 == 2) ? 0 : $urandom_range(9);
    cmd_queue.push_back(c);
    total_words++;
  endfunction

  // Driver
  timer_cmd_t  next_cmd;
  bit          staged = 1'b0;
  int unsigned idle_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        advance_table(in_kind, in_interval_seconds, in_target_id);
        words_taken++;
      end
      // hold the word while the block is busy
      if (!(start && busy)) begin
        if (!staged && cmd_queue.size() != 0) begin
          next_cmd  = cmd_queue.pop_front();
          staged    = 1'b1;
          idle_left = next_cmd.gap;
        end
        if (staged && idle_left == 0) begin
          start               <= 1'b1;
          in_kind             <= next_cmd.kind;
          in_interval_seconds <= next_cmd.interval;
          in_target_id        <= next_cmd.target;
          staged = 1'b0;
        end else begin
          start <= 1'b0;
          if (staged)
            idle_left--;
        end
      end
    end
  end

  // Monitor
  report_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (due_reports.size() == 0) begin
        $error("unexpected word: status %0d task_number %0d last %0d",
               out_status, out_task_number, out_last);
        error_count++;
      end else begin
        want = due_reports.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_task_number !== want.task_number) begin
          $error("task_number: expected %0d, got %0d", want.task_number, out_task_number);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int unsigned real_cmds;
    int unsigned adds_issued;
    int unsigned pick;
    int unsigned sel;
    logic [2:0]  kind;
    logic [30:0] interval;
    logic [6:0]  target;

    // Directed opening
    queue_cmd(ptt_pkg::KIND_TICK, 31'($urandom), 7'($urandom)); // nothing due, empty table
    queue_cmd(ptt_pkg::KIND_ADD, 31'd0, 7'd0);                 // zero period rejected
    queue_cmd(ptt_pkg::KIND_PAUSE, 31'd0, 7'd0);               // id zero
    queue_cmd(ptt_pkg::KIND_PAUSE, 31'd0, 7'd1);               // unclaimed id
    queue_cmd(ptt_pkg::KIND_ADD, 31'd1, 7'd0);
    queue_cmd(ptt_pkg::KIND_ADD, 31'h7FFF_FFFF, 7'd0);
    queue_cmd(ptt_pkg::KIND_ADD, 31'd3, 7'd0);
    queue_cmd(ptt_pkg::KIND_TICK, 31'h7FFF_FFFF, 7'h7F);
    queue_cmd(ptt_pkg::KIND_PAUSE, 31'd0, 7'd1);
    queue_cmd(ptt_pkg::KIND_PAUSE, 31'd0, 7'd1);               // already paused
    queue_cmd(ptt_pkg::KIND_TICK, 31'd0, 7'd0);
    queue_cmd(ptt_pkg::KIND_TICK, 31'd0, 7'd0);
    queue_cmd(ptt_pkg::KIND_RESUME, 31'd0, 7'd1);
    queue_cmd(ptt_pkg::KIND_RESUME, 31'd0, 7'd1);              // already running
    queue_cmd(ptt_pkg::KIND_RESUME, 31'd0, 7'd3);
    queue_cmd(ptt_pkg::KIND_DELETE, 31'd0, 7'd2);
    queue_cmd(ptt_pkg::KIND_DELETE, 31'd0, 7'd2);              // deleted id
    queue_cmd(ptt_pkg::KIND_PAUSE, 31'd0, 7'd2);
    queue_cmd(ptt_pkg::KIND_RESUME, 31'd0, 7'd64);
    queue_cmd(ptt_pkg::KIND_DELETE, 31'h5555_5555, 7'h7F);
    for (int k = KIND_UNUSED_FIRST; k < 8; k++)
      queue_cmd(3'(k), 31'($urandom), 7'($urandom));
    queue_cmd(ptt_pkg::KIND_TICK, 31'($urandom), 7'($urandom));

    // Random traffic: fill the table with short periods, then keep ticking past full
    real_cmds   = 0;
    adds_issued = 3;
    while (real_cmds < RANDOM_CMDS) begin
      pick     = $urandom_range(99);
      interval = 31'($urandom);
      target   = 7'($urandom);
      if (pick < 40) begin
        kind = ptt_pkg::KIND_TICK;
      end else if (pick < 64) begin
        kind = ptt_pkg::KIND_ADD;
        sel  = $urandom_range(19);
        if (sel < 8)
          interval = 31'd1;
        else if (sel < 14)
          interval = 31'($urandom_range(6, 2));
        else if (sel < 16)
          interval = 31'($urandom_range(40, 7));
        else if (sel == 19)
          interval = 31'd0;
        if (interval != '0 && adds_issued < SLOTS)
          adds_issued++;
      end else if (pick < 93) begin
        sel    = $urandom_range(9);
        kind   = (sel < 4) ? ptt_pkg::KIND_PAUSE :
                 (sel < 8) ? ptt_pkg::KIND_RESUME : ptt_pkg::KIND_DELETE;
        target = 7'($urandom_range(adds_issued, 1));
      end else if (pick < 97) begin
        sel  = $urandom_range(2);
        kind = (sel == 0) ? ptt_pkg::KIND_PAUSE :
               (sel == 1) ? ptt_pkg::KIND_RESUME : ptt_pkg::KIND_DELETE;
        // out-of-range ids
        if ($urandom_range(1) == 0)
          target = 7'd0;
        else
          target = 7'($urandom_range(127, SLOTS + 1));
      end else begin
        kind = 3'($urandom_range(7, KIND_UNUSED_FIRST));
      end
      queue_cmd(kind, interval, target);
      if (kind < KIND_UNUSED_FIRST)
        real_cmds++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words)
      @(posedge clk);
    while (due_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

FILE: periodic_task_timer_table.f
design/ptt_pkg.sv
design/ptt_ram.sv
design/ptt_ctrl.sv
design/ptt_dp.sv
design/periodic_task_timer_table.sv
dv/testbench.sv
